// File: rtl/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types, codes and widths of the ordered list block.
// ----------------------------------------------------------------------------
package olid_pkg;

    // fixed payload widths of the channels
    localparam int CMD_W    = 2;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 8;

    // defaults for the top level parameters
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_LOCATE = 2'd3
    } olid_cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } olid_status_t;

    // per-cell control from the list controller
    typedef struct packed {
        logic load;        // take the incoming word
        logic take_left;   // take the lower neighbor's entry (insert shift)
        logic take_right;  // take the upper neighbor's entry (delete shift)
        logic occupied;    // cell lies below the current length
    } olid_cell_ctrl_t;

endpackage

// File: rtl/olid_in_if.sv
// ----------------------------------------------------------------------------
// olid_in_if
// Command channel: valid/ready handshake with command, position and value.
// ----------------------------------------------------------------------------
interface olid_in_if
    import olid_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// File: rtl/olid_out_if.sv
// ----------------------------------------------------------------------------
// olid_out_if
// Result channel: valid/ready handshake with status, read value, locate
// position and list length.
// ----------------------------------------------------------------------------
interface olid_out_if
    import olid_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [POS_W-1:0]    found_position;
    logic [LEN_W-1:0]    list_length;

    modport source (output valid, output status, output read_value,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input list_length, output ready);
endinterface

// File: rtl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of up to CAPACITY signed words built as a row of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry per cell, and a length
// count. On each command transaction (insert, delete, get, locate) all cells
// shift toward or away from the addressed position in parallel, get selects
// the addressed cell, and locate compares every cell with the key at once
// and picks the lowest match. The result is held in an output register, so
// a new command is taken every cycle as long as the result side keeps up; a
// stalled result blocks further commands. Positions are 1-based; on any
// error the list is left as it was. The list is empty after reset and needs
// no clearing time.
module ordered_list_insert_delete
    import olid_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    olid_in_if.sink   in_ch,
    olid_out_if.source out_ch
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = POS_W + 1;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  read_value_reg;
    logic [POS_W-1:0]    found_reg;
    logic [LEN_W-1:0]    length_reg;

    logic                accept;
    olid_cmd_t           cmd;
    olid_status_t        status_next;
    logic [VALUE_W-1:0]  read_next;
    logic [POS_W-1:0]    found_next;

    logic signed [63:0]  value_ext;
    logic [DATA_WIDTH-1:0] word;
    logic [CMP_W-1:0]    pos_c;
    logic [CMP_W-1:0]    pos0_c;
    logic [CMP_W-1:0]    count_c;
    logic                full;
    logic                empty;
    logic                ins_pos_ok;
    logic                acc_pos_ok;
    logic                ins_ok;
    logic                del_ok;

    olid_cell_ctrl_t       ctrl [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   match;
    logic signed [DATA_WIDTH-1:0] sel_word;
    logic signed [63:0]    sel_ext;
    logic [LEN_W-1:0]      found_enc;

    // handshake: take a command when the result register is free
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd         = olid_cmd_t'(in_ch.cmd);

    // incoming value cut or sign-extended to the data width
    assign value_ext = 64'(signed'(in_ch.value));
    assign word      = value_ext[DATA_WIDTH-1:0];

    // position checks
    assign pos_c      = CMP_W'(in_ch.position);
    assign pos0_c     = pos_c - CMP_W'(1);
    assign count_c    = CMP_W'(count_reg);
    assign full       = (count_c >= CMP_W'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign ins_pos_ok = (pos_c != '0) && (pos_c <= count_c + CMP_W'(1));
    assign acc_pos_ok = (pos_c != '0) && (pos_c <= count_c);
    assign ins_ok     = accept && (cmd == CMD_INSERT) && !full && ins_pos_ok;
    assign del_ok     = accept && (cmd == CMD_DELETE) && !empty && acc_pos_ok;

    // cell row
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (k == 0)
        begin : g_first
            assign left_data = word;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[k];
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[k+1];
        end

        assign ctrl[k].load       = ins_ok && (CMP_W'(k) == pos0_c);
        assign ctrl[k].take_left  = ins_ok && (CMP_W'(k) > pos0_c)
                                    && (CMP_W'(k) <= count_c);
        assign ctrl[k].take_right = del_ok && (CMP_W'(k) >= pos0_c)
                                    && (CMP_W'(k + 1) < count_c);
        assign ctrl[k].occupied   = (CMP_W'(k) < count_c);

        olid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl[k]),
            .word       (word),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[k]),
            .match      (match[k])
        );
    end

    // locate encoder
    olid_find #(
        .CAPACITY (CAPACITY)
    ) u_find (
        .match          (match),
        .found_position (found_enc)
    );

    // addressed cell for get and delete
    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (CMP_W'(k) == pos0_c)
            begin
                sel_word = sel_word | cell_data[k];
            end
        end
    end

    assign sel_ext = 64'(sel_word);

    // result and next length
    always_comb
    begin
        status_next = ST_OK;
        read_next   = '0;
        found_next  = '0;
        count_next  = count_reg;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (!ins_pos_ok)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!acc_pos_ok)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    read_next  = sel_ext[VALUE_W-1:0];
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            CMD_GET:
            begin
                if (!acc_pos_ok)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    read_next = sel_ext[VALUE_W-1:0];
                end
            end
            CMD_LOCATE:
            begin
                found_next = found_enc;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // length count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_next;
            found_reg      <= found_next;
            length_reg     <= LEN_W'(count_next);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.read_value     = read_value_reg;
    assign out_ch.found_position = found_reg;
    assign out_ch.list_length    = length_reg;

    // length never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("list length above capacity");

    // a good insert grows the list by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert did not grow the list");

    // an error leaves the length alone
    a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (status_next != ST_OK) |=> $stable(count_reg))
        else $error("failed command changed the length");

    // a locate hit lies within the list and reports ok
    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (found_reg != '0) |->
        (status_reg == ST_OK) && (LEN_W'(found_reg) <= length_reg))
        else $error("locate position outside the list");

endmodule

// File: rtl/olid_cell.sv
// ----------------------------------------------------------------------------
// olid_cell
// One list slot: holds an entry, shifts to or from its neighbors and
// compares its entry with the locate key.
// ----------------------------------------------------------------------------
module olid_cell
    import olid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  olid_cell_ctrl_t       ctrl,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match
);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    // next entry from the shift controls
    always_comb
    begin
        priority if (ctrl.load)
        begin
            entry_next = word;
        end
        else if (ctrl.take_left)
        begin
            entry_next = left_data;
        end
        else if (ctrl.take_right)
        begin
            entry_next = right_data;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data  = entry_reg;
    assign match = ctrl.occupied && (entry_reg == word);

endmodule

// File: rtl/olid_find.sv
// ----------------------------------------------------------------------------
// olid_find
// Locate encoder: turns the cell match vector into the 1-based position of
// the lowest matching cell, 0 when no cell matches.
// ----------------------------------------------------------------------------
module olid_find
    import olid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic [CAPACITY-1:0] match,
    output logic [LEN_W-1:0]    found_position
);

    logic [CAPACITY-1:0] lowest;

    // isolate the lowest set bit
    assign lowest = match & (~match + CAPACITY'(1));

    // one-hot to position
    always_comb
    begin
        found_position = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (lowest[k])
            begin
                found_position = found_position | LEN_W'(k + 1);
            end
        end
    end

endmodule
